### design/tshc_pkg.sv
// Shared types and constants for the time-sorted hit window clusterer.
`timescale 1ns / 1ps
package tshc_pkg;

    localparam int TIME_W      = 21;
    localparam int PROD_W      = 16;
    localparam int BPROD_W     = 20;
    localparam int MAX_RESULTS = 64;
    localparam int NPOP_W      = 7;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_GET    = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_HIT    = 2'd1,
        KIND_EMPTY  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_BCID_CLOCK = 2'd0,
        REG_TAC_SLOPE  = 2'd1,
        REG_WINDOW     = 2'd2
    } reg_idx_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_POP  = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_val;
        logic [3:0]        plane;
        logic [5:0]        strip;
        logic [9:0]        adc;
    } hit_t;

    typedef struct packed {
        op_t  op;
        hit_t hit;
    } q_item_t;

endpackage

### design/tshc_front.sv
// Front end: accepts items, computes hit time, pushes into the queue.
`timescale 1ns / 1ps
module tshc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic [3:0]           plane,
    input  logic [5:0]           strip,
    input  logic [9:0]           adc,
    input  logic [11:0]          bcid,
    input  logic [7:0]           tdc,
    input  logic [7:0]           bcid_clock,
    input  logic [7:0]           tac_slope,
    output logic                 push,
    output tshc_pkg::q_item_t    push_item,
    input  logic                 q_full
);
    import tshc_pkg::*;

    logic               s1_valid_reg, s1_valid_next;
    logic               op_reg;
    logic [3:0]         plane_reg;
    logic [5:0]         strip_reg;
    logic [9:0]         adc_reg;
    logic [BPROD_W-1:0] bprod_reg;
    logic [PROD_W-1:0]  tprod_reg;
    logic [PROD_W:0]    div_sum;
    logic [7:0]         fine;
    logic               take;

    assign push     = s1_valid_reg && !q_full;
    assign in_ready = !s1_valid_reg || !q_full;
    assign take     = in_valid && in_ready;

    // x/255 for 16-bit x: (x + (x>>8) + 1) >> 8
    assign div_sum = {1'b0, tprod_reg} + {9'd0, tprod_reg[15:8]} + {{PROD_W{1'b0}}, 1'b1};
    assign fine    = div_sum[15:8];

    always_comb
    begin
        push_item.op            = op_t'(op_reg);
        push_item.hit.time_val  = {1'b0, bprod_reg} + {13'd0, fine};
        push_item.hit.plane     = plane_reg;
        push_item.hit.strip     = strip_reg;
        push_item.hit.adc       = adc_reg;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (push)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg    <= op;
            plane_reg <= plane;
            strip_reg <= strip;
            adc_reg   <= adc;
            bprod_reg <= BPROD_W'(bcid) * BPROD_W'(bcid_clock);
            tprod_reg <= PROD_W'(tdc) * PROD_W'(tac_slope);
        end
    end

endmodule

### design/tshc_queue.sv
// Two-entry queue between the front end and the store engine.
`timescale 1ns / 1ps
module tshc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tshc_pkg::q_item_t    push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output tshc_pkg::q_item_t    head
);
    import tshc_pkg::*;

    q_item_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

### design/tshc_back.sv
// Store engine: sorted cell chain, status/empty results and cluster pops.
`timescale 1ns / 1ps
module tshc_back #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [9:0]           cluster_window,
    input  logic                 q_valid,
    input  tshc_pkg::q_item_t    q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           kind,
    output logic                 ready_res,
    output logic                 overflow,
    output logic [20:0]          hit_time,
    output logic [3:0]           hit_plane,
    output logic [5:0]           hit_strip,
    output logic [9:0]           hit_adc,
    output logic                 last
);
    import tshc_pkg::*;

    localparam int CW = $clog2(STORE_DEPTH + 1);

    hit_t              store_reg [STORE_DEPTH];
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [TIME_W-1:0] newest_reg, newest_next;
    logic [TIME_W:0]   limit_reg, limit_next;
    logic [NPOP_W-1:0] npop_reg, npop_next;
    back_state_t       state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    kind_t             kind_reg, kind_next;
    logic              rdy_reg, rdy_next;
    logic              ovf_reg, ovf_next;
    hit_t              hit_reg, hit_next;
    logic              last_reg, last_next;

    logic              slot_free, do_ins, do_shift, full, empty;
    logic              ready_now, ready_ins, last_pop;
    logic [TIME_W-1:0] t_new, oldest_ins, newest_ins;
    logic [STORE_DEPTH-1:0] gt;

    assign slot_free = !out_valid_reg || out_ready;
    assign t_new     = q_item.hit.time_val;
    assign full      = (cnt_reg == CW'(STORE_DEPTH));
    assign empty     = (cnt_reg == '0);
    assign ready_now = !empty
        && ((newest_reg - store_reg[0].time_val) > {{(TIME_W-10){1'b0}}, cluster_window});

    always_comb
    begin
        oldest_ins = (empty || store_reg[0].time_val > t_new) ? t_new : store_reg[0].time_val;
        newest_ins = (empty || t_new > newest_reg) ? t_new : newest_reg;
        ready_ins  = full ? ready_now
            : ((newest_ins - oldest_ins) > {{(TIME_W-10){1'b0}}, cluster_window});
    end

    assign last_pop = (npop_reg == NPOP_W'(MAX_RESULTS - 1)) || (cnt_reg == CW'(1))
                      || ({1'b0, store_reg[1].time_val} > limit_reg);

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (slot_free && q_valid && q_item.op == OP_GET && ready_now)
                    state_next = ST_POP;
            ST_POP:
                if (slot_free && last_pop)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control and result outputs
    always_comb
    begin
        q_pop          = 1'b0;
        do_ins         = 1'b0;
        do_shift       = 1'b0;
        cnt_next       = cnt_reg;
        newest_next    = newest_reg;
        limit_next     = limit_reg;
        npop_next      = npop_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        rdy_next       = rdy_reg;
        ovf_next       = ovf_reg;
        hit_next       = hit_reg;
        last_next      = last_reg;
        unique case (state_reg)
            ST_IDLE:
                if (slot_free && q_valid)
                begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    rdy_next       = 1'b0;
                    ovf_next       = 1'b0;
                    hit_next       = '0;
                    last_next      = 1'b1;
                    if (q_item.op == OP_INSERT)
                    begin
                        kind_next = KIND_STATUS;
                        rdy_next  = ready_ins;
                        ovf_next  = full;
                        if (!full)
                        begin
                            do_ins      = 1'b1;
                            cnt_next    = cnt_reg + CW'(1);
                            newest_next = newest_ins;
                        end
                    end
                    else if (!ready_now)
                        kind_next = KIND_EMPTY;
                    else
                    begin
                        // first hit is emitted in the pop state
                        out_valid_next = 1'b0;
                        limit_next = {1'b0, store_reg[0].time_val}
                                     + {{(TIME_W-9){1'b0}}, cluster_window};
                        npop_next  = '0;
                    end
                end
            ST_POP:
                if (slot_free)
                begin
                    do_shift       = 1'b1;
                    cnt_next       = cnt_reg - CW'(1);
                    npop_next      = npop_reg + NPOP_W'(1);
                    out_valid_next = 1'b1;
                    kind_next      = KIND_HIT;
                    rdy_next       = 1'b0;
                    ovf_next       = 1'b0;
                    hit_next       = store_reg[0];
                    last_next      = last_pop;
                end
            default:
                ;
        endcase
    end

    // Sorted cell chain: gt marks cells whose hit moves up on insert
    for (genvar i = 0; i < STORE_DEPTH; i++)
    begin : g_cell
        assign gt[i] = (CW'(i) < cnt_reg) ? (store_reg[i].time_val > t_new)
                                          : (CW'(i) == cnt_reg);
        always_ff @(posedge clk)
        begin
            if (do_ins && gt[i])
            begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                    store_reg[i] <= store_reg[(i > 0) ? i - 1 : 0];
                else
                    store_reg[i] <= q_item.hit;
            end
            else if (do_shift && i < STORE_DEPTH - 1)
                store_reg[i] <= store_reg[(i < STORE_DEPTH - 1) ? i + 1 : i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        newest_reg <= newest_next;
        limit_reg  <= limit_next;
        npop_reg   <= npop_next;
        kind_reg   <= kind_next;
        rdy_reg    <= rdy_next;
        ovf_reg    <= ovf_next;
        hit_reg    <= hit_next;
        last_reg   <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign ready_res = rdy_reg;
    assign overflow  = ovf_reg;
    assign hit_time  = hit_reg.time_val;
    assign hit_plane = hit_reg.plane;
    assign hit_strip = hit_reg.strip;
    assign hit_adc   = hit_reg.adc;
    assign last      = last_reg;

endmodule

### design/time_sorted_hit_window_clusterer_top.sv
// Top level of the time-sorted hit window clusterer.
`timescale 1ns / 1ps
// Usage:
//   in channel  (in_valid/in_ready): op=0 inserts a hit, op=1 asks for a cluster.
//   out channel (out_valid/out_ready): one status item per insert, one empty
//     item per get that finds the store not ready, else the cluster hits in
//     time order, the final one flagged by last.
//   cfg channel (cfg_valid/cfg_ready, always ready): index 0 bcid_clock,
//     1 tac_slope, 2 cluster_window; other indexes are ignored. Write only
//     while the block is idle.
// Path: an item passes through the front-end register, the queue and the
//   result register; a cluster's first hit also passes through the pop state.
// Throughput: the front end takes one item per cycle into a 2-entry queue
//   while it has room; the store engine takes inserts, empty results and
//   popped hits one at a time, plus a setup step per cluster (one item per
//   cycle for inserts, set by the single insert per cycle of the sorted cell chain).
// Reset empties the store and queue and loads register defaults; no clearing
//   pass is needed. When out_ready is low the result register holds and the
//   queue fills, after which in_ready drops.
module time_sorted_hit_window_clusterer_top #(
    parameter int STORE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [3:0]  plane,
    input  logic [5:0]  strip,
    input  logic [9:0]  adc,
    input  logic [11:0] bcid,
    input  logic [7:0]  tdc,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic        ready_res,
    output logic        overflow,
    output logic [20:0] hit_time,
    output logic [3:0]  hit_plane,
    output logic [5:0]  hit_strip,
    output logic [9:0]  hit_adc,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    import tshc_pkg::*;

    logic [7:0] bcid_clock_reg;
    logic [7:0] tac_slope_reg;
    logic [9:0] window_reg;

    logic    push, q_full, q_pop, q_valid;
    q_item_t push_item, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcid_clock_reg <= 8'd25;
            tac_slope_reg  <= 8'd125;
            window_reg     <= 10'd30;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_BCID_CLOCK: bcid_clock_reg <= cfg_data[7:0];
                REG_TAC_SLOPE:  tac_slope_reg  <= cfg_data[7:0];
                REG_WINDOW:     window_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    tshc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .plane      (plane),
        .strip      (strip),
        .adc        (adc),
        .bcid       (bcid),
        .tdc        (tdc),
        .bcid_clock (bcid_clock_reg),
        .tac_slope  (tac_slope_reg),
        .push       (push),
        .push_item  (push_item),
        .q_full     (q_full)
    );

    tshc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    tshc_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cluster_window (window_reg),
        .q_valid        (q_valid),
        .q_item         (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .ready_res      (ready_res),
        .overflow       (overflow),
        .hit_time       (hit_time),
        .hit_plane      (hit_plane),
        .hit_strip      (hit_strip),
        .hit_adc        (hit_adc),
        .last           (last)
    );

endmodule
